// ----- src/sid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sid_pkg;

    // coordinate width of every input field
    localparam int COORD_BITS = 16;
    // crossing point width
    localparam int CROSS_BITS = COORD_BITS + 2;
    // magnitude of the denominator and of the normalized position along a
    localparam int DEN_BITS   = 2 * COORD_BITS;
    // offset dividend and aligned divisor width
    localparam int NUM_BITS   = 3 * COORD_BITS + 2;
    // quotient bits, one per division cell
    localparam int QUO_BITS   = COORD_BITS + 2;

    // beat passed from one division cell to the next
    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic [NUM_BITS-1:0]          rem_x;
        logic [NUM_BITS-1:0]          rem_y;
        logic [NUM_BITS-1:0]          divs;
        logic [QUO_BITS-1:0]          quo_x;
        logic [QUO_BITS-1:0]          quo_y;
    } div_beat_t;

endpackage

`default_nettype wire

// ----- src/sid_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sid_prep (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_origin_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_origin_y,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_delta_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_delta_y,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_origin_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_origin_y,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_delta_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_delta_y,
    output logic                                       dn_valid,
    input  wire logic                                  dn_stall,
    output sid_pkg::div_beat_t                         dn_beat
);
    import sid_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int PW   = 2 * C + 2;
    localparam int NW   = 2 * C + 3;
    localparam int PXW  = 3 * C + 1;
    localparam int SUMW = NUM_BITS + 1;

    // stage 1: cross products
    logic                      v1_reg;
    logic                      vert1_reg;
    logic signed [C-1:0]       ax1_reg, ay1_reg, adx1_reg, ady1_reg;
    logic signed [2*C:0]       den1_reg;
    logic signed [PW-1:0]      tn1_reg, sn1_reg;
    // stage 2: sign normalize and span check
    logic                      v2_reg, hit2_reg;
    logic signed [C-1:0]       ax2_reg, ay2_reg, adx2_reg, ady2_reg;
    logic [DEN_BITS-1:0]       den2_reg, tn2_reg;
    // stage 3: numerator products
    logic                      v3_reg, hit3_reg;
    logic signed [C-1:0]       ax3_reg, ay3_reg;
    logic [DEN_BITS-1:0]       den3_reg;
    logic signed [PXW-1:0]     px3_reg, py3_reg;
    // stage 4: offset dividend
    logic                      v4_reg;
    div_beat_t                 beat4_reg;

    logic stall1, stall2, stall3, stall4;

    assign stall4   = v4_reg && dn_stall;
    assign stall3   = v3_reg && stall4;
    assign stall2   = v2_reg && stall3;
    assign stall1   = v1_reg && stall2;
    assign in_stall = stall1;
    assign dn_valid = v4_reg;
    assign dn_beat  = beat4_reg;

    // stage 1 logic
    logic signed [C:0]     dx, dy;
    logic signed [2*C:0]   den_next;
    logic signed [PW-1:0]  tn_next, sn_next;

    always_comb
    begin
        dx       = (C+1)'(b_origin_x) - (C+1)'(a_origin_x);
        dy       = (C+1)'(b_origin_y) - (C+1)'(a_origin_y);
        den_next = (2*C+1)'(a_delta_x * b_delta_y) - (2*C+1)'(a_delta_y * b_delta_x);
        tn_next  = PW'(dx * b_delta_y) - PW'(dy * b_delta_x);
        sn_next  = PW'(dx * a_delta_y) - PW'(dy * a_delta_x);
    end

    // stage 2 logic
    logic signed [NW-1:0] den_n, tn_n, sn_n;
    logic                 hit_next;

    always_comb
    begin
        if (den1_reg < 0)
        begin
            den_n = -NW'(den1_reg);
            tn_n  = -NW'(tn1_reg);
            sn_n  = -NW'(sn1_reg);
        end
        else
        begin
            den_n = NW'(den1_reg);
            tn_n  = NW'(tn1_reg);
            sn_n  = NW'(sn1_reg);
        end
        hit_next = !vert1_reg && (den1_reg != 0) && (tn_n >= 0) && (tn_n <= den_n)
                   && (sn_n >= 0) && (sn_n <= den_n);
    end

    // stage 4 logic: 2p + d + d * 2^(C+1), positive for every hit
    logic signed [SUMW-1:0] nx_sum, ny_sum, d_term;

    always_comb
    begin
        d_term = SUMW'($signed({1'b0, den3_reg})) + (SUMW'($signed({1'b0, den3_reg})) <<< (C+1));
        nx_sum = (SUMW'(px3_reg) <<< 1) + d_term;
        ny_sum = (SUMW'(py3_reg) <<< 1) + d_term;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (!stall1) v1_reg <= in_valid;
            if (!stall2) v2_reg <= v1_reg;
            if (!stall3) v3_reg <= v2_reg;
            if (!stall4) v4_reg <= v3_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!stall1)
        begin
            vert1_reg <= (a_delta_x == 0) || (b_delta_x == 0);
            ax1_reg   <= a_origin_x;
            ay1_reg   <= a_origin_y;
            adx1_reg  <= a_delta_x;
            ady1_reg  <= a_delta_y;
            den1_reg  <= den_next;
            tn1_reg   <= tn_next;
            sn1_reg   <= sn_next;
        end
        if (!stall2)
        begin
            hit2_reg <= hit_next;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            adx2_reg <= adx1_reg;
            ady2_reg <= ady1_reg;
            den2_reg <= den_n[DEN_BITS-1:0];
            tn2_reg  <= tn_n[DEN_BITS-1:0];
        end
        if (!stall3)
        begin
            hit3_reg <= hit2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            den3_reg <= den2_reg;
            px3_reg  <= PXW'(adx2_reg * $signed({1'b0, tn2_reg}));
            py3_reg  <= PXW'(ady2_reg * $signed({1'b0, tn2_reg}));
        end
        if (!stall4)
        begin
            beat4_reg.hit   <= hit3_reg;
            beat4_reg.ax    <= ax3_reg;
            beat4_reg.ay    <= ay3_reg;
            beat4_reg.rem_x <= nx_sum[NUM_BITS-1:0];
            beat4_reg.rem_y <= ny_sum[NUM_BITS-1:0];
            beat4_reg.divs  <= NUM_BITS'(den3_reg) << (C + 2);
            beat4_reg.quo_x <= '0;
            beat4_reg.quo_y <= '0;
        end
    end

endmodule

`default_nettype wire

// ----- src/sid_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sid_div_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_stall,
    input  wire sid_pkg::div_beat_t  up_beat,
    output logic                     dn_valid,
    input  wire logic                dn_stall,
    output sid_pkg::div_beat_t       dn_beat
);
    import sid_pkg::*;

    logic        valid_reg;
    div_beat_t   beat_reg;
    div_beat_t   beat_next;
    logic [NUM_BITS:0] trial_x, trial_y;

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_beat  = beat_reg;

    // one restoring step for both quotients against the shared divisor
    always_comb
    begin
        trial_x   = {1'b0, up_beat.rem_x} - {1'b0, up_beat.divs};
        trial_y   = {1'b0, up_beat.rem_y} - {1'b0, up_beat.divs};
        beat_next = up_beat;
        beat_next.rem_x = trial_x[NUM_BITS] ? up_beat.rem_x : trial_x[NUM_BITS-1:0];
        beat_next.rem_y = trial_y[NUM_BITS] ? up_beat.rem_y : trial_y[NUM_BITS-1:0];
        beat_next.quo_x = {up_beat.quo_x[QUO_BITS-2:0], ~trial_x[NUM_BITS]};
        beat_next.quo_y = {up_beat.quo_y[QUO_BITS-2:0], ~trial_y[NUM_BITS]};
        beat_next.divs  = up_beat.divs >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall)
            beat_reg <= beat_next;
    end

    // on a hit the remainder stays below the divisor of the step just done
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && beat_reg.hit |->
            ({1'b0, beat_reg.rem_x} < {beat_reg.divs, 1'b0})
            && ({1'b0, beat_reg.rem_y} < {beat_reg.divs, 1'b0}))
        else $error("division remainder out of range");

endmodule

`default_nettype wire

// ----- src/segment_intersection_2d_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Intersects two 2-D segments given as origin and direction in signed Q12.4 and
// returns a hit flag with the crossing point in Q14.4, rounded to nearest with
// ties up; a vertical segment, parallel lines or a crossing outside either x
// span gives hit 0 and a zero point. One segment pair is taken every cycle
// unless in_stall is high and passes stages of cross products, span checks
// and numerator products, then a chain of 18 division cells that each settle
// one quotient bit of both coordinates, then the output register. A stall on
// the output holds only the stages that are full, so empty stages still fill.
module segment_intersection_2d_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_origin_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_origin_y,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_delta_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] a_delta_y,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_origin_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_origin_y,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_delta_x,
    input  wire logic signed [sid_pkg::COORD_BITS-1:0] b_delta_y,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       hit,
    output logic signed [sid_pkg::CROSS_BITS-1:0]      cross_x,
    output logic signed [sid_pkg::CROSS_BITS-1:0]      cross_y
);
    import sid_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SW  = C + 4;

    logic      link_valid [QUO_BITS+1];
    logic      link_stall [QUO_BITS+1];
    div_beat_t link_beat  [QUO_BITS+1];

    // front stages
    sid_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_origin_x (a_origin_x),
        .a_origin_y (a_origin_y),
        .a_delta_x  (a_delta_x),
        .a_delta_y  (a_delta_y),
        .b_origin_x (b_origin_x),
        .b_origin_y (b_origin_y),
        .b_delta_x  (b_delta_x),
        .b_delta_y  (b_delta_y),
        .dn_valid   (link_valid[0]),
        .dn_stall   (link_stall[0]),
        .dn_beat    (link_beat[0])
    );

    // division chain, most significant quotient bit first
    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        sid_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_stall (link_stall[i]),
            .up_beat  (link_beat[i]),
            .dn_valid (link_valid[i+1]),
            .dn_stall (link_stall[i+1]),
            .dn_beat  (link_beat[i+1])
        );
    end

    // remove the quotient offset, add the origin and saturate
    div_beat_t            fin;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [SW-1:0] sat_hi, sat_lo;
    logic signed [CROSS_BITS-1:0] cx_next, cy_next;
    logic                 out_valid_reg, hit_reg;
    logic signed [CROSS_BITS-1:0] cross_x_reg, cross_y_reg;
    logic                 fin_stall;

    assign fin       = link_beat[QUO_BITS];
    assign fin_stall = out_valid_reg && out_stall;
    assign link_stall[QUO_BITS] = fin_stall;

    always_comb
    begin
        sat_hi = SW'((1 <<< (CROSS_BITS - 1)) - 1);
        sat_lo = -sat_hi - SW'(1);
        sum_x  = SW'(fin.ax) + $signed(SW'(fin.quo_x)) - SW'(1 <<< C);
        sum_y  = SW'(fin.ay) + $signed(SW'(fin.quo_y)) - SW'(1 <<< C);
        if (sum_x > sat_hi)
            cx_next = sat_hi[CROSS_BITS-1:0];
        else if (sum_x < sat_lo)
            cx_next = sat_lo[CROSS_BITS-1:0];
        else
            cx_next = sum_x[CROSS_BITS-1:0];
        if (sum_y > sat_hi)
            cy_next = sat_hi[CROSS_BITS-1:0];
        else if (sum_y < sat_lo)
            cy_next = sat_lo[CROSS_BITS-1:0];
        else
            cy_next = sum_y[CROSS_BITS-1:0];
        if (!fin.hit)
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!fin_stall)
            out_valid_reg <= link_valid[QUO_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (!fin_stall)
        begin
            hit_reg     <= fin.hit;
            cross_x_reg <= cx_next;
            cross_y_reg <= cy_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (cross_x == 0) && (cross_y == 0))
        else $error("miss beat with nonzero point");

    // backpressure at the input only comes from a held output beat
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

// ----- sim/tb_segment_intersection_2d_unit.sv -----
`timescale 1ns / 1ps

module tb_segment_intersection_2d_unit;
    import sid_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 40;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;

    typedef struct packed {
        logic   hit;
        cross_t x;
        cross_t y;
    } crossing_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t a_origin_x, a_origin_y, a_delta_x, a_delta_y;
    coord_t b_origin_x, b_origin_y, b_delta_x, b_delta_y;
    logic   out_valid;
    logic   out_stall;
    logic   hit;
    cross_t cross_x;
    cross_t cross_y;

    crossing_t crossing_queue[$];
    int        error_count;
    int        idle_cycles;
    bit        stall_enable;

    segment_intersection_2d_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_origin_x (a_origin_x),
        .a_origin_y (a_origin_y),
        .a_delta_x  (a_delta_x),
        .a_delta_y  (a_delta_y),
        .b_origin_x (b_origin_x),
        .b_origin_y (b_origin_y),
        .b_delta_x  (b_delta_x),
        .b_delta_y  (b_delta_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .cross_x    (cross_x),
        .cross_y    (cross_y)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // floor of n / d for d > 0
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic cross_t clamp_cross(longint v);
        longint hi;
        hi = (longint'(1) <<< (CROSS_BITS - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return cross_t'(v);
    endfunction

    // crossing point of the two supporting lines, checked against both x spans
    function automatic crossing_t segment_crossing(coord_t ax, coord_t ay, coord_t adx,
                                                   coord_t ady, coord_t bx, coord_t by,
                                                   coord_t bdx, coord_t bdy);
        longint    dx, dy, den, tn, sn;
        crossing_t r;
        dx  = longint'(bx) - longint'(ax);
        dy  = longint'(by) - longint'(ay);
        den = longint'(adx) * bdy - longint'(ady) * bdx;
        tn  = dx * bdy - dy * bdx;
        sn  = dx * ady - dy * adx;
        r   = '0;
        if (adx == 0 || bdx == 0 || den == 0)
            return r;
        if (den < 0)
        begin
            den = -den;
            tn  = -tn;
            sn  = -sn;
        end
        if (tn < 0 || tn > den || sn < 0 || sn > den)
            return r;
        r.hit = 1'b1;
        r.x   = clamp_cross(longint'(ax) + floor_quot(2 * (longint'(adx) * tn) + den, 2 * den));
        r.y   = clamp_cross(longint'(ay) + floor_quot(2 * (longint'(ady) * tn) + den, 2 * den));
        return r;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // send one segment pair and queue its expected crossing
    task automatic send_pair(coord_t ax, coord_t ay, coord_t adx, coord_t ady,
                             coord_t bx, coord_t by, coord_t bdx, coord_t bdy,
                             bit gaps);
        int gap;
        gap = gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        a_origin_x <= ax;
        a_origin_y <= ay;
        a_delta_x  <= adx;
        a_delta_y  <= ady;
        b_origin_x <= bx;
        b_origin_y <= by;
        b_delta_x  <= bdx;
        b_delta_y  <= bdy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        crossing_queue.push_back(segment_crossing(ax, ay, adx, ady, bx, by, bdx, bdy));
    endtask

    // drop valid for one cycle between test phases
    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // extremes, vertical, parallel, degenerate, endpoints and ties
    task automatic test_directed();
        send_pair(0, 0, 16, 16, 0, 16, 16, -16, 0);
        send_pair(0, 0, 0, 16, 0, 0, 16, 0, 0);
        send_pair(0, 0, 16, 0, 8, -8, 0, 16, 0);
        send_pair(0, 0, 16, 16, 0, 8, 32, 32, 0);
        send_pair(0, 0, 16, 16, 0, 0, 32, 32, 0);
        send_pair(0, 0, 0, 0, 0, 0, 16, 16, 0);
        send_pair(0, 0, 16, 0, 16, -16, 16, 32, 0);
        send_pair(0, 0, 16, 0, 16, 0, 16, 16, 0);
        send_pair(0, 0, 3, 1, 0, 1, 3, -1, 0);
        send_pair(0, 0, 1, 1, 0, 1, 2, -1, 0);
        send_pair(0, 0, 16, 16, 100, 0, 16, 16, 0);
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0);
        send_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 0);
        send_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 0);
        send_pair(32767, -32768, -32768, 32767, -32768, 0, -1, 1, 0);
        send_pair(-1, -1, -1, -1, -1, 0, -1, 1, 0);
        send_pair(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                  16'haaaa, 16'h5555, 0);
        send_pair(100, 0, -200, 50, -100, 30, 200, -60, 0);
        release_input();
    endtask

    // crossing pairs: b is built across a so most beats hit
    task automatic test_random(int count);
        coord_t ax, ay, adx, ady, bx, by, bdx, bdy;
        int     mode;
        int     px, py, tspan;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 6)
            begin
                tspan = (mode < 3) ? 2000 : 30000;
                ax  = coord_t'($urandom_range(0, 2 * tspan) - tspan);
                ay  = coord_t'($urandom_range(0, 2 * tspan) - tspan);
                adx = coord_t'($urandom_range(0, 2 * tspan) - tspan);
                ady = coord_t'($urandom_range(0, 2 * tspan) - tspan);
                px  = int'(ax) + int'(adx) * int'($urandom_range(0, 16)) / 16;
                py  = int'(ay) + int'(ady) * int'($urandom_range(0, 16)) / 16;
                bdx = coord_t'($urandom_range(0, 2 * tspan) - tspan);
                bdy = coord_t'($urandom_range(0, 2 * tspan) - tspan);
                bx  = coord_t'(px - int'(bdx) * int'($urandom_range(0, 16)) / 16);
                by  = coord_t'(py - int'(bdy) * int'($urandom_range(0, 16)) / 16);
            end
            else
            begin
                ax  = coord_t'($urandom());
                ay  = coord_t'($urandom());
                adx = coord_t'($urandom());
                ady = coord_t'($urandom());
                bx  = coord_t'($urandom());
                by  = coord_t'($urandom());
                bdx = (mode == 9) ? coord_t'(0) : coord_t'($urandom());
                bdy = coord_t'($urandom());
                if (mode == 8)
                begin
                    bdx = adx;
                    bdy = ady;
                end
            end
            send_pair(ax, ay, adx, ady, bx, by, bdx, bdy, 1);
        end
        release_input();
    endtask

    // sender holds off until the pipeline has drained completely
    task automatic test_drain_pause();
        while (crossing_queue.size() != 0)
            @(posedge clk);
        send_pair(0, 0, 32, 16, 0, 16, 32, -16, 0);
        send_pair(0, 0, 32, 16, 0, 16, 32, -16, 0);
        release_input();
    endtask

    // stall pattern on the result side
    always @(posedge clk)
    begin
        if (!stall_enable)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) == 0)
            out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 9) != 0 && $urandom_range(0, 3) == 0)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 4) == 0);
    end

    // compare each result beat with the oldest expected crossing
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (crossing_queue.size() == 0)
            begin
                $display("%0t: unexpected beat hit=%0d x=%0d y=%0d", $time, hit, cross_x,
                         cross_y);
                error_count++;
            end
            else
            begin
                want = crossing_queue.pop_front();
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
                    error_count++;
                end
                if (cross_x !== want.x)
                begin
                    $display("%0t: cross_x expected %0d actual %0d", $time, want.x, cross_x);
                    error_count++;
                end
                if (cross_y !== want.y)
                begin
                    $display("%0t: cross_y expected %0d actual %0d", $time, want.y, cross_y);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        error_count  = 0;
        idle_cycles  = 0;
        stall_enable = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        a_origin_x   = '0;
        a_origin_y   = '0;
        a_delta_x    = '0;
        a_delta_y    = '0;
        b_origin_x   = '0;
        b_origin_y   = '0;
        b_delta_x    = '0;
        b_delta_y    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_enable = 1'b1;
        test_random(900);
        test_drain_pause();
        test_random(900);
        while (crossing_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
